// ===== design/pfc_pkg.sv =====
// Package for the pixel format converter: types, codes and fixed-point coefficient words.
`default_nettype none

package pfc_pkg;

   // Fraction bits of the YUV coefficient words.
   localparam int COEF_FRAC_BITS = 16;
   // Largest coefficient magnitude is about 277.5, so nine integer bits and a sign.
   localparam int COEF_W = COEF_FRAC_BITS + 10;
   // Coefficient times a zero-extended 8-bit sample.
   localparam int PROD_W = COEF_W + 9;
   // Three products and an offset, with headroom.
   localparam int ACC_W = COEF_W + 11;
   // Integer part of the accumulator after the shift.
   localparam int QUOT_W = ACC_W - COEF_FRAC_BITS;

   localparam longint MICRO_DEN = 64'sd1000000;
   localparam longint MICRO_HALF = 64'sd500000;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      SRC_YUV    = 2'd0,
      SRC_RGB565 = 2'd1,
      SRC_XRGB   = 2'd2
   } pfc_src_type;

   typedef enum logic {
      REG_SOURCE_FORMAT = 1'b0,
      REG_OUTPUT_DEPTH  = 1'b1
   } pfc_reg_type;

   typedef struct packed {
      logic [1:0] source_format;
      logic       output_depth;
   } pfc_cfg_type;

   typedef struct packed {
      logic [7:0]  luma;
      logic [7:0]  chroma_u;
      logic [7:0]  chroma_v;
      logic [31:0] packed_pixel;
   } pfc_req_type;

   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
   } pfc_rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] cy;
      logic signed [COEF_W-1:0] cu;
      logic signed [COEF_W-1:0] cv;
      logic signed [COEF_W-1:0] off;
   } pfc_coef_type;

   // round(scale * micro / 1e6 * 2^F), ties away from zero.
   function automatic logic signed [COEF_W-1:0] coef_word(input longint scale,
                                                           input longint micro);
      longint mag;
      longint w;
      mag = (micro < 0) ? -micro : micro;
      w = (scale * mag * (64'sd1 <<< COEF_FRAC_BITS) + MICRO_HALF) / MICRO_DEN;
      if (micro < 0) begin
         w = -w;
      end
      return w[COEF_W-1:0];
   endfunction

   localparam logic [7:0] SCALE_WIDE = 8'd255;
   localparam logic [7:0] SCALE_5BIT = 8'd31;
   localparam logic [7:0] SCALE_6BIT = 8'd63;

   localparam pfc_coef_type COEF_B_WIDE = '{
      cy: coef_word(255, 4565), cu: coef_word(255, 1),
      cv: coef_word(255, 6250), off: coef_word(255, -872000)};
   localparam pfc_coef_type COEF_G_WIDE = '{
      cy: coef_word(255, 4565), cu: coef_word(255, -1542),
      cv: coef_word(255, -3183), off: coef_word(255, 531000)};
   localparam pfc_coef_type COEF_R_WIDE = '{
      cy: coef_word(255, 4565), cu: coef_word(255, 7935),
      cv: coef_word(255, 0), off: coef_word(255, -1088000)};

   localparam pfc_coef_type COEF_B_565 = '{
      cy: coef_word(31, 4565), cu: coef_word(31, 1),
      cv: coef_word(31, 6250), off: coef_word(31, -872000)};
   localparam pfc_coef_type COEF_G_565 = '{
      cy: coef_word(63, 4565), cu: coef_word(63, -1542),
      cv: coef_word(63, -3183), off: coef_word(63, 531000)};
   localparam pfc_coef_type COEF_R_565 = '{
      cy: coef_word(31, 4565), cu: coef_word(31, 7935),
      cv: coef_word(31, 0), off: coef_word(31, -1088000)};

endpackage

`default_nettype wire

// ===== design/pfc_csr.sv =====
// Configuration registers of the pixel format converter behind an APB-style port.
`default_nettype none

module pfc_csr
   import pfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      pfc_cfg_type           cfg
);

   logic [1:0]  source_format_ff;
   logic [1:0]  source_format_in;
   logic        output_depth_ff;
   logic        output_depth_in;
   logic        wr_en;
   pfc_reg_type reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel = pfc_reg_type'(csr_paddr[2]);

   always_comb begin
      source_format_in = source_format_ff;
      output_depth_in = output_depth_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_SOURCE_FORMAT: source_format_in = csr_pwdata[1:0];
            REG_OUTPUT_DEPTH:  output_depth_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_format_ff <= SRC_YUV;
         output_depth_ff <= 1'b1;
      end else begin
         source_format_ff <= source_format_in;
         output_depth_ff <= output_depth_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_SOURCE_FORMAT: csr_prdata = {{(CSR_DATA_W-2){1'b0}}, source_format_ff};
         REG_OUTPUT_DEPTH:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, output_depth_ff};
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.source_format = source_format_ff;
   assign cfg.output_depth = output_depth_ff;

endmodule

`default_nettype wire

// ===== design/pfc_yuv_chan.sv =====
// One color channel of the YUV conversion: weighted sum, clamp and truncate.
`default_nettype none

module pfc_yuv_chan
   import pfc_pkg::*;
(
   input  wire pfc_coef_type coef,
   input  wire logic [7:0]   scale,
   input  wire logic [7:0]   y,
   input  wire logic [7:0]   u,
   input  wire logic [7:0]   v,
   output      logic [7:0]   value
);

   logic signed [PROD_W-1:0] prod_y;
   logic signed [PROD_W-1:0] prod_u;
   logic signed [PROD_W-1:0] prod_v;
   logic signed [ACC_W-1:0]  acc;
   logic [QUOT_W-1:0]        quot;

   assign prod_y = coef.cy * $signed({1'b0, y});
   assign prod_u = coef.cu * $signed({1'b0, u});
   assign prod_v = coef.cv * $signed({1'b0, v});

   assign acc = {{(ACC_W-PROD_W){prod_y[PROD_W-1]}}, prod_y}
              + {{(ACC_W-PROD_W){prod_u[PROD_W-1]}}, prod_u}
              + {{(ACC_W-PROD_W){prod_v[PROD_W-1]}}, prod_v}
              + {{(ACC_W-COEF_W){coef.off[COEF_W-1]}}, coef.off};

   assign quot = acc[ACC_W-1:COEF_FRAC_BITS];

   // A negative sum gives zero; otherwise the integer part is limited to the scale.
   always_comb begin
      if (acc[ACC_W-1]) begin
         value = 8'd0;
      end else if (quot > {{(QUOT_W-8){1'b0}}, scale}) begin
         value = scale;
      end else begin
         value = quot[7:0];
      end
   end

endmodule

`default_nettype wire

// ===== design/pfc_convert.sv =====
// Conversion logic of the pixel format converter from one input word to one result word.
`default_nettype none

module pfc_convert
   import pfc_pkg::*;
(
   input  wire pfc_cfg_type cfg,
   input  wire pfc_req_type req,
   output      pfc_rsp_type rsp
);

   logic [7:0]   b0;
   logic [7:0]   b1;
   logic [7:0]   b2;
   logic [7:0]   b3;
   logic         wide;
   pfc_coef_type coef_b;
   pfc_coef_type coef_g;
   pfc_coef_type coef_r;
   logic [7:0]   scale_rb;
   logic [7:0]   scale_g;
   logic [7:0]   yuv_b;
   logic [7:0]   yuv_g;
   logic [7:0]   yuv_r;

   assign b0 = req.packed_pixel[7:0];
   assign b1 = req.packed_pixel[15:8];
   assign b2 = req.packed_pixel[23:16];
   assign b3 = req.packed_pixel[31:24];
   assign wide = cfg.output_depth;

   assign coef_b = wide ? COEF_B_WIDE : COEF_B_565;
   assign coef_g = wide ? COEF_G_WIDE : COEF_G_565;
   assign coef_r = wide ? COEF_R_WIDE : COEF_R_565;
   assign scale_rb = wide ? SCALE_WIDE : SCALE_5BIT;
   assign scale_g = wide ? SCALE_WIDE : SCALE_6BIT;

   pfc_yuv_chan u_chan_b (
      .coef  (coef_b),
      .scale (scale_rb),
      .y     (req.luma),
      .u     (req.chroma_u),
      .v     (req.chroma_v),
      .value (yuv_b)
   );

   pfc_yuv_chan u_chan_g (
      .coef  (coef_g),
      .scale (scale_g),
      .y     (req.luma),
      .u     (req.chroma_u),
      .v     (req.chroma_v),
      .value (yuv_g)
   );

   pfc_yuv_chan u_chan_r (
      .coef  (coef_r),
      .scale (scale_rb),
      .y     (req.luma),
      .u     (req.chroma_u),
      .v     (req.chroma_v),
      .value (yuv_r)
   );

   always_comb begin
      rsp = '0;
      case (pfc_src_type'(cfg.source_format))
         SRC_YUV: begin
            if (wide) begin
               rsp.out_byte0 = yuv_b;
               rsp.out_byte1 = yuv_g;
               rsp.out_byte2 = yuv_r;
            end else begin
               rsp.out_byte0 = {yuv_g[2:0], yuv_b[4:0]};
               rsp.out_byte1 = {yuv_r[4:0], yuv_g[5:3]};
            end
         end
         SRC_RGB565: begin
            if (wide) begin
               rsp.out_byte0 = {b0[4:0], 3'b000};
               rsp.out_byte1 = {b1[2:0], b0[7:5], 2'b00};
               rsp.out_byte2 = {b1[7:3], 3'b000};
            end else begin
               rsp.out_byte0 = b0;
               rsp.out_byte1 = b1;
            end
         end
         SRC_XRGB: begin
            if (wide) begin
               rsp.out_byte0 = b3;
               rsp.out_byte1 = b2;
               rsp.out_byte2 = b1;
            end else begin
               // Red from byte 1, green from byte 2, blue from byte 3, top bits kept.
               rsp.out_byte0 = {b2[4:2], b3[7:3]};
               rsp.out_byte1 = {b1[7:3], b2[7:5]};
            end
         end
         default: rsp = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/pixel_format_converter_unit.sv =====
// Top level of the pixel format converter: handshakes, input register and result register.
//
// Usage: each word on the req channel carries one pixel, either a YUV triple
// (luma, chroma_u, chroma_v) or a packed RGB565 or xRGB word in packed_pixel.
// Each accepted word yields exactly one rsp word with three bytes in memory
// order: BGR in 24-bit mode, or the low and high RGB565 bytes and a zero byte
// in 16-bit mode. The source format and output depth are set over the csr
// port, which must only be written while no word is in flight.
// A word accepted at a clock edge is captured in the input register, converted
// in one pass of combinational logic and stored in the result register once
// that register is free, at which point rsp_valid rises. Throughput is one word
// per cycle while rsp_stall is low; the two registers form a two-stage pipe.
// When rsp_stall is high the result register holds its word, and the input
// register holds its own; req_stall rises only when both are full and the
// receiver is stalling, so a new word is still taken while a result waits.
// Reset is synchronous: both stages are emptied, source format returns to
// YUV and output depth to 24-bit.
`default_nettype none

module pixel_format_converter_unit
   import pfc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire pfc_req_type           req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      pfc_rsp_type           rsp_data,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   pfc_cfg_type cfg;
   logic        in_valid_ff;
   logic        in_valid_in;
   pfc_req_type in_data_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   pfc_rsp_type out_data_ff;
   pfc_rsp_type out_data_in;
   logic        out_load;
   logic        req_take;

   pfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pfc_convert u_convert (
      .cfg (cfg),
      .req (in_data_ff),
      .rsp (out_data_in)
   );

   // The result register can take a new word when it is empty or its word leaves now.
   assign out_load = ~out_valid_ff | ~rsp_stall;
   // The input register is free when it is empty or its word moves on this cycle.
   assign req_stall = in_valid_ff & ~out_load;
   assign req_take = req_valid & ~req_stall;

   assign in_valid_in = req_take | (in_valid_ff & ~out_load);
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (out_load & in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   // An accepted word always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted word not held in input register");

   // A word in the input register moves to the result register when it can.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff & out_load) |=> out_valid_ff)
      else $error("converted word lost on the way to the result register");

   // A blocked word in the input register stays put.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff & ~out_load) |=> (in_valid_ff & $stable(in_data_ff)))
      else $error("blocked input word was overwritten or dropped");

   // Nothing enters the result register from an empty input stage.
   assert property (@(posedge clock) disable iff (reset)
      (~out_valid_ff & ~in_valid_ff) |=> ~out_valid_ff)
      else $error("result appeared without an input word");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the pixel format converter unit.
`timescale 1ns / 100ps

module testbench
   import pfc_pkg::*;
();

   // Register codes that the package does not name.
   localparam logic       DEPTH_565  = 1'b0;
   localparam logic       DEPTH_BGR  = 1'b1;

   // Affine YUV terms in millionths, with the chroma names kept as the block uses them.
   localparam longint MU_LUMA  = 4565;
   localparam longint MU_B_U   = 1;
   localparam longint MU_B_V   = 6250;
   localparam longint MU_B_OFF = -872000;
   localparam longint MU_G_U   = -1542;
   localparam longint MU_G_V   = -3183;
   localparam longint MU_G_OFF = 531000;
   localparam longint MU_R_U   = 7935;
   localparam longint MU_R_V   = 0;
   localparam longint MU_R_OFF = -1088000;

   localparam int RANDOM_PER_SETTING = 84;
   localparam int SETTING_COUNT = 8;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   pfc_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pfc_rsp_type rsp_data;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Words waiting to be sent, and the converted pixels still owed by the block.
   pfc_req_type pixel_q[$];
   pfc_rsp_type converted_q[$];

   // The register values as the block should hold them.
   logic [1:0] cur_format;
   logic       cur_depth;

   // Set at each rising edge when the word on the request side was taken.
   logic req_taken = 1'b0;

   // Idle rates in percent for the sender and the receiver.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int mismatch_count = 0;

   pixel_format_converter_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Fixed-point coefficient word: round(scale * micro / 1e6 * 2^F), where a tie
   // goes away from zero. The magnitude is rounded and the sign put back after.
   function automatic longint q_word(input int scale, input longint micro);
      longint mag;
      longint w;
      mag = (micro < 0) ? -micro : micro;
      w = (longint'(scale) * mag * (longint'(1) << COEF_FRAC_BITS) + 500000) / 1000000;
      return (micro < 0) ? -w : w;
   endfunction

   // One YUV output channel: exact sum of products, negative sums give zero,
   // the fraction is dropped and the level is limited to the channel scale.
   function automatic logic [7:0] yuv_level(input int scale, input logic [7:0] y,
                                            input logic [7:0] u, input logic [7:0] v,
                                            input longint cu, input longint cv,
                                            input longint off);
      longint acc;
      longint level;
      acc = q_word(scale, MU_LUMA) * longint'(y) + q_word(scale, cu) * longint'(u)
          + q_word(scale, cv) * longint'(v) + q_word(scale, off);
      if (acc < 0) begin
         return 8'd0;
      end
      level = acc >>> COEF_FRAC_BITS;
      if (level > scale) begin
         level = scale;
      end
      return level[7:0];
   endfunction

   // RGB565 in memory order: low byte holds the low green bits and blue.
   function automatic pfc_rsp_type pack_565(input logic [4:0] r5, input logic [5:0] g6,
                                            input logic [4:0] b5);
      pfc_rsp_type res;
      res.out_byte0 = {g6[2:0], b5};
      res.out_byte1 = {r5, g6[5:3]};
      res.out_byte2 = 8'd0;
      return res;
   endfunction

   // Predicts the result word for one pixel under the given register values.
   function automatic pfc_rsp_type convert_pixel(input pfc_req_type px,
                                                 input logic [1:0] fmt, input logic depth);
      pfc_rsp_type res;
      int          rb_scale;
      int          g_scale;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      logic [7:0]  b3;
      {b3, b2, b1, b0} = px.packed_pixel;
      res = '0;
      case (fmt)
         SRC_YUV: begin
            rb_scale = (depth == DEPTH_BGR) ? 255 : 31;
            g_scale = (depth == DEPTH_BGR) ? 255 : 63;
            blue = yuv_level(rb_scale, px.luma, px.chroma_u, px.chroma_v,
                             MU_B_U, MU_B_V, MU_B_OFF);
            green = yuv_level(g_scale, px.luma, px.chroma_u, px.chroma_v,
                              MU_G_U, MU_G_V, MU_G_OFF);
            red = yuv_level(rb_scale, px.luma, px.chroma_u, px.chroma_v,
                            MU_R_U, MU_R_V, MU_R_OFF);
            if (depth == DEPTH_BGR) begin
               res.out_byte0 = blue;
               res.out_byte1 = green;
               res.out_byte2 = red;
            end else begin
               res = pack_565(red[4:0], green[5:0], blue[4:0]);
            end
         end
         SRC_RGB565: begin
            if (depth == DEPTH_BGR) begin
               res.out_byte0 = {b0[4:0], 3'b000};
               res.out_byte1 = {b1[2:0], b0[7:5], 2'b00};
               res.out_byte2 = {b1[7:3], 3'b000};
            end else begin
               res.out_byte0 = b0;
               res.out_byte1 = b1;
            end
         end
         SRC_XRGB: begin
            if (depth == DEPTH_BGR) begin
               res.out_byte0 = b3;
               res.out_byte1 = b2;
               res.out_byte2 = b1;
            end else begin
               res = pack_565(b1[7:3], b2[7:2], b3[7:3]);
            end
         end
         default: begin
            // The unused format code yields an all-zero word.
            res = '0;
         end
      endcase
      return res;
   endfunction

   task automatic note_failure(input string what, input logic [23:0] want,
                               input logic [23:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   // Monitor. Everything is sampled at the rising edge, where the block's own
   // registers have not yet taken their new values. A result is checked before
   // the new prediction is queued; as every word passes both the input and the result
   // registers, a result leaving in a cycle is never the word entering that cycle.
   always @(posedge clock) begin : monitor
      pfc_rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (reset) begin
         cur_format = SRC_YUV;
         cur_depth = DEPTH_BGR;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            if (converted_q.size() == 0) begin
               note_failure("unexpected result word", 24'd0, rsp_data);
            end else begin
               want = converted_q.pop_front();
               if (rsp_data.out_byte0 !== want.out_byte0) begin
                  note_failure("out_byte0", want.out_byte0, rsp_data.out_byte0);
               end
               if (rsp_data.out_byte1 !== want.out_byte1) begin
                  note_failure("out_byte1", want.out_byte1, rsp_data.out_byte1);
               end
               if (rsp_data.out_byte2 !== want.out_byte2) begin
                  note_failure("out_byte2", want.out_byte2, rsp_data.out_byte2);
               end
            end
         end
         if (req_taken) begin
            converted_q.push_back(convert_pixel(req_data, cur_format, cur_depth));
         end
         // Track register writes; only the low bits of each register survive.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[CSR_ADDR_W-1:2] == REG_SOURCE_FORMAT) begin
               cur_format = csr_pwdata[1:0];
            end else if (csr_paddr[CSR_ADDR_W-1:2] == REG_OUTPUT_DEPTH) begin
               cur_depth = csr_pwdata[0];
            end
         end
      end
   end

   // Driver. At each falling edge the receiver's stall is redrawn, and a new word
   // is presented once the current one was taken. A word that is held back keeps
   // its payload, and valid is decided without looking at the stall.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pixel_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Register write: a setup phase, then the access phase that completes on pready.
   task automatic csr_write(input pfc_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Waits until every word has been sent and every result has come back, then
   // lets the two-stage pipe settle.
   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_q.size() != 0 || req_valid || converted_q.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Stimulus. Three idling profiles, each run through every register setting:
   // all four format codes, including the unused one, at both output depths.
   // The first profile opens each setting with corner words.
   initial begin : stimulus
      pfc_req_type px;
      logic [1:0]  fmt;
      logic        depth;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         for (int s = 0; s < SETTING_COUNT; s++) begin
            // Settings step through the format codes in order, 24-bit output first.
            fmt = 2'(s >> 1);
            depth = (s % 2 == 0) ? DEPTH_BGR : DEPTH_565;
            wait_drained();
            // The very first setting equals the reset values, so it runs unwritten.
            // Every write carries random upper bits that the register must drop.
            if (mode != 0 || s != 0) begin
               csr_write(REG_SOURCE_FORMAT, ($urandom() & 32'hFFFF_FFFC) | fmt);
               csr_write(REG_OUTPUT_DEPTH, ($urandom() & 32'hFFFF_FFFE) | depth);
            end

            if (mode == 0) begin
               case (fmt)
                  SRC_YUV: begin
                     // All eight corners of the YUV cube, reaching both clamps.
                     for (int c = 0; c < 8; c++) begin
                        px.luma = c[0] ? 8'hFF : 8'h00;
                        px.chroma_u = c[1] ? 8'hFF : 8'h00;
                        px.chroma_v = c[2] ? 8'hFF : 8'h00;
                        px.packed_pixel = $urandom();
                        pixel_q.push_back(px);
                     end
                  end
                  SRC_RGB565: begin
                     // The unused upper bytes are set where the pixel is clear.
                     px = '1;
                     px.packed_pixel = 32'hFFFF_0000;
                     pixel_q.push_back(px);
                     px = '0;
                     px.packed_pixel = 32'h0000_FFFF;
                     pixel_q.push_back(px);
                  end
                  SRC_XRGB: begin
                     px = '0;
                     px.packed_pixel = 32'hFFFF_FF00;
                     pixel_q.push_back(px);
                     px = '1;
                     px.packed_pixel = 32'h0000_00FF;
                     pixel_q.push_back(px);
                  end
                  default: begin
                     px = '1;
                     pixel_q.push_back(px);
                  end
               endcase
            end

            // Random words; fields that the format ignores carry random bits too.
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
               px.luma = 8'($urandom_range(255));
               px.chroma_u = 8'($urandom_range(255));
               px.chroma_v = 8'($urandom_range(255));
               px.packed_pixel = $urandom();
               pixel_q.push_back(px);
            end
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("pixel_format_converter_unit verification clean");
      end else begin
         $display("pixel_format_converter_unit verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run under the heaviest idling.
   initial begin
      #2_000_000;
      $display("pixel_format_converter_unit verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/pfc_pkg.sv
design/pfc_csr.sv
design/pfc_yuv_chan.sv
design/pfc_convert.sv
design/pixel_format_converter_unit.sv
dv/testbench.sv
